FILE: src/lsgpf_pkg.sv
// Shared constants, register indexes and the arctangent table of the ground point filter.
package lsgpf_pkg;

   localparam int COORD_BITS_DEF   = 20;
   localparam int CORDIC_STEPS_DEF = 16;

   // angle accumulator in microdegrees, signed
   localparam int ANGLE_BITS = 29;
   // guard bits above the coordinate width inside the CORDIC datapath
   localparam int CORDIC_GUARD = 21;

   // CORDIC gain 1.6467602 in Q16
   localparam logic signed [17:0] GAIN_Q16 = 18'sd107922;
   // floor(2^32 / 10000), quotient fixed up by one compare afterwards
   localparam logic [18:0] RECIP_1E4 = 19'd429496;
   localparam int RECIP_SHIFT = 32;
   localparam logic [13:0] UDEG_PER_CDEG = 14'd10000;
   localparam logic [12:0] ROUND_HALF    = 13'd5000;

   localparam int CFG_ADDR_BITS = 5;
   localparam logic [2:0] REG_MOUNT_ANGLE     = 3'd0;
   localparam logic [2:0] REG_ANGLE_TOLERANCE = 3'd1;
   localparam logic [2:0] REG_GROUND_Z_LIMIT  = 3'd2;
   localparam logic [2:0] REG_ORIGIN_X_LIMIT  = 3'd3;
   localparam logic [2:0] REG_RANGE_RADIUS    = 3'd4;

   localparam logic signed [14:0] MOUNT_RESET  = 15'sd0;
   localparam logic [13:0]        TOL_RESET    = 14'd500;
   localparam logic signed [19:0] GZ_RESET     = -20'sd400;
   localparam logic [18:0]        OX_RESET     = 19'd10;
   localparam logic [18:0]        RADIUS_RESET = 19'd10000;

   // atan(2^-i) in microdegrees, rounded
   function automatic logic [27:0] atan_udeg(input logic [4:0] idx);
      logic [27:0] v;
      case (idx)
         5'd0:  v = 28'd45000000;
         5'd1:  v = 28'd26565051;
         5'd2:  v = 28'd14036243;
         5'd3:  v = 28'd7125016;
         5'd4:  v = 28'd3576334;
         5'd5:  v = 28'd1789911;
         5'd6:  v = 28'd895174;
         5'd7:  v = 28'd447614;
         5'd8:  v = 28'd223811;
         5'd9:  v = 28'd111906;
         5'd10: v = 28'd55953;
         5'd11: v = 28'd27976;
         5'd12: v = 28'd13988;
         5'd13: v = 28'd6994;
         5'd14: v = 28'd3497;
         5'd15: v = 28'd1749;
         5'd16: v = 28'd874;
         5'd17: v = 28'd437;
         5'd18: v = 28'd219;
         5'd19: v = 28'd109;
         5'd20: v = 28'd55;
         5'd21: v = 28'd27;
         5'd22: v = 28'd14;
         5'd23: v = 28'd7;
         5'd24: v = 28'd3;
         5'd25: v = 28'd2;
         5'd26: v = 28'd1;
         default: v = 28'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/lsgpf_req_if.sv
// Point input channel: valid/ready handshake with the point coordinates.
interface lsgpf_req_if #(
   parameter int COORD_BITS = lsgpf_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;
   logic                         frame_end;

   modport source (output valid, point_x, point_y, point_z, frame_end, input ready);
   modport sink   (input valid, point_x, point_y, point_z, frame_end, output ready);
endinterface

FILE: src/lsgpf_rsp_if.sv
// Labelled point output channel: valid/ready handshake with the point and its flags.
interface lsgpf_rsp_if #(
   parameter int COORD_BITS = lsgpf_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic signed [COORD_BITS-1:0] out_z;
   logic                         is_ground;
   logic                         near_origin;
   logic                         kept;
   logic                         in_range;
   logic                         out_last;

   modport source (output valid, out_x, out_y, out_z, is_ground, near_origin, kept,
                   in_range, out_last, input ready);
   modport sink   (input valid, out_x, out_y, out_z, is_ground, near_origin, kept,
                   in_range, out_last, output ready);
endinterface

FILE: src/lidar_slope_ground_point_filter.sv
// Sequence: a point with a held predecessor runs the CORDIC row in P1 and P2, then steps through F1, F2,
// F3, SQ and PUSH to offer its first result; at frame end SQ and PUSH run again for a second result.
// Throughput: one point at a time; the row of CORDIC cells is run twice per pair.
// A point with nothing held and no frame end is only stored as the held point, with no CORDIC pass.
// Synchronous reset clears the held point, the sequencer and the output stage and loads
// the register reset values; there is no clearing pass.
module lidar_slope_ground_point_filter #(
   parameter int COORD_BITS   = lsgpf_pkg::COORD_BITS_DEF,
   parameter int CORDIC_STEPS = lsgpf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   lsgpf_req_if.sink                              req,
   lsgpf_rsp_if.source                            rsp,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lsgpf_pkg::CFG_ADDR_BITS-1:0]    csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);
   localparam int CB    = COORD_BITS;
   localparam int CW    = COORD_BITS + lsgpf_pkg::CORDIC_GUARD;
   localparam int AW    = lsgpf_pkg::ANGLE_BITS;
   localparam int CNT_W = $clog2(CORDIC_STEPS);
   localparam int ZW    = (CB > 20) ? CB : 20;
   localparam int XW    = (CB > 19) ? CB : 19;
   localparam int SQW   = (2 * CB + 1 > 38) ? 2 * CB + 1 : 38;
   localparam int AVW   = AW - 1;
   localparam int PW    = AVW + 19;
   localparam int QW    = PW - lsgpf_pkg::RECIP_SHIFT;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_P1   = 4'd1;
   localparam logic [3:0] ST_P2   = 4'd2;
   localparam logic [3:0] ST_F1   = 4'd3;
   localparam logic [3:0] ST_F2   = 4'd4;
   localparam logic [3:0] ST_F3   = 4'd5;
   localparam logic [3:0] ST_SQ   = 4'd6;
   localparam logic [3:0] ST_PUSH = 4'd7;

   // configuration
   logic signed [14:0] mount_ff;
   logic [13:0]        tol_ff;
   logic signed [19:0] gz_ff;
   logic [18:0]        ox_ff;
   logic [18:0]        rr_ff;
   logic [2:0]         csr_idx;
   logic               csr_wr;

   // sequencer and point state
   logic [3:0]             state_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic signed [CB-1:0]   held_x_ff, held_y_ff, held_z_ff;
   logic                   hg_ff, ho_ff, have_ff;
   logic signed [CB-1:0]   cur_x_ff, cur_y_ff, cur_z_ff;
   logic                   cur_last_ff;
   logic signed [CB:0]     dz_ff;
   logic                   dz_zero_ff;
   logic                   cg_ff, co_ff;
   logic [AVW-1:0]         av_ff;
   logic                   aneg_ff;
   logic [PW-1:0]          prod_ff;
   logic [QW-1:0]          q_ff;

   // result being prepared
   logic signed [CB-1:0]   e_x_ff, e_y_ff, e_z_ff;
   logic                   eg_ff, eo_ff, elast_ff;
   logic [2*CB-1:0]        sqx_ff, sqy_ff;
   logic [37:0]            rsq_ff;

   // output stage
   logic                   rsp_valid_ff;
   logic signed [CB-1:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                   rsp_g_ff, rsp_o_ff, rsp_k_ff, rsp_r_ff, rsp_l_ff;

   // datapath
   logic signed [CB:0]     dxs, dys, dzs;
   logic [CB:0]            adx;
   logic signed [CW-1:0]   ch_x, ch_y, res_x, res_y;
   logic signed [AW-1:0]   ch_a, res_a;
   logic [AVW-1:0]         a_mag;
   logic [AVW-1:0]         rem;
   logic [QW-1:0]          qc;
   logic signed [15:0]     pitch_s;
   logic signed [16:0]     dev;
   logic [16:0]            adev;
   logic                   cg_new, co_new;
   logic                   accept, push_ok, last_step;
   logic [CB-1:0]          ux, uy;
   logic                   kept_w;

   function automatic logic [CB-1:0] mag(input logic signed [CB-1:0] v);
      logic [CB-1:0] u;
      u = v;
      if (v[CB-1]) begin
         u = ~u + 1'b1;
      end
      return u;
   endfunction

   function automatic logic z_low(input logic signed [CB-1:0] z,
                                  input logic signed [19:0] lim);
      return ZW'(z) < ZW'(lim);
   endfunction

   function automatic logic x_near(input logic signed [CB-1:0] x, input logic [18:0] lim);
      return XW'(mag(x)) < XW'(lim);
   endfunction

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mount_ff <= lsgpf_pkg::MOUNT_RESET;
         tol_ff   <= lsgpf_pkg::TOL_RESET;
         gz_ff    <= lsgpf_pkg::GZ_RESET;
         ox_ff    <= lsgpf_pkg::OX_RESET;
         rr_ff    <= lsgpf_pkg::RADIUS_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            lsgpf_pkg::REG_MOUNT_ANGLE:     mount_ff <= csr_pwdata[14:0];
            lsgpf_pkg::REG_ANGLE_TOLERANCE: tol_ff   <= csr_pwdata[13:0];
            lsgpf_pkg::REG_GROUND_Z_LIMIT:  gz_ff    <= csr_pwdata[19:0];
            lsgpf_pkg::REG_ORIGIN_X_LIMIT:  ox_ff    <= csr_pwdata[18:0];
            lsgpf_pkg::REG_RANGE_RADIUS:    rr_ff    <= csr_pwdata[18:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         lsgpf_pkg::REG_MOUNT_ANGLE:     csr_prdata = 32'({1'b0, mount_ff});
         lsgpf_pkg::REG_ANGLE_TOLERANCE: csr_prdata = 32'(tol_ff);
         lsgpf_pkg::REG_GROUND_Z_LIMIT:  csr_prdata = 32'({1'b0, gz_ff});
         lsgpf_pkg::REG_ORIGIN_X_LIMIT:  csr_prdata = 32'(ox_ff);
         lsgpf_pkg::REG_RANGE_RADIUS:    csr_prdata = 32'(rr_ff);
         default:                        csr_prdata = 32'd0;
      endcase
   end

   // ---------------- CORDIC row ----------------
   assign dxs = {req.point_x[CB-1], req.point_x} - {held_x_ff[CB-1], held_x_ff};
   assign dys = {req.point_y[CB-1], req.point_y} - {held_y_ff[CB-1], held_y_ff};
   assign dzs = {req.point_z[CB-1], req.point_z} - {held_z_ff[CB-1], held_z_ff};
   assign adx = dxs[CB] ? (~dxs + 1'b1) : dxs;

   always_comb begin
      if (state_ff == ST_P1) begin
         // second pass: keep the horizontal magnitude, bring in the scaled height
         ch_x = res_x;
         ch_y = dz_ff * lsgpf_pkg::GAIN_Q16;
      end else begin
         ch_x = CW'({adx, 16'b0});
         ch_y = CW'($signed({dys, 16'b0}));
      end
      ch_a = '0;
   end

   lsgpf_cordic_chain #(.W(CW), .AW(AW), .STEPS(CORDIC_STEPS)) u_chain (
      .clock (clock),
      .src_x (ch_x),
      .src_y (ch_y),
      .src_a (ch_a),
      .res_x (res_x),
      .res_y (res_y),
      .res_a (res_a)
   );

   // ---------------- rounding and tests ----------------
   assign a_mag = res_a[AW-1] ? AVW'(-res_a) : AVW'(res_a);
   assign rem   = av_ff - AVW'(q_ff * lsgpf_pkg::UDEG_PER_CDEG);

   always_comb begin
      qc = q_ff;
      if (rem >= AVW'(lsgpf_pkg::UDEG_PER_CDEG)) begin
         qc = q_ff + 1'b1;
      end
      pitch_s = 16'(qc);
      if (aneg_ff) begin
         pitch_s = -pitch_s;
      end
      if (dz_zero_ff) begin
         pitch_s = '0;
      end
      dev    = 17'(pitch_s) - 17'(mount_ff);
      adev   = dev[16] ? 17'(-dev) : 17'(dev);
      cg_new = (adev <= 17'(tol_ff)) || z_low(held_z_ff, gz_ff);
      co_new = x_near(held_x_ff, ox_ff);
   end

   assign ux     = mag(e_x_ff);
   assign uy     = mag(e_y_ff);
   assign kept_w = !eg_ff && !eo_ff;

   // ---------------- sequencer ----------------
   assign req.ready  = (state_ff == ST_IDLE);
   assign accept     = req.valid && req.ready;
   assign push_ok    = !rsp_valid_ff || rsp.ready;
   assign last_step  = (cnt_ff == CNT_W'(CORDIC_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         have_ff  <= 1'b0;
         hg_ff    <= 1'b0;
         ho_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (have_ff) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_P1;
                  end else if (req.frame_end) begin
                     state_ff <= ST_SQ;
                  end else begin
                     held_x_ff <= req.point_x;
                     held_y_ff <= req.point_y;
                     held_z_ff <= req.point_z;
                     hg_ff     <= 1'b0;
                     ho_ff     <= 1'b0;
                     have_ff   <= 1'b1;
                  end
               end
            end
            ST_P1: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (last_step) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_P2;
               end
            end
            ST_P2: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (last_step) begin
                  state_ff <= ST_F1;
               end
            end
            ST_F1: state_ff <= ST_F2;
            ST_F2: state_ff <= ST_F3;
            ST_F3: state_ff <= ST_SQ;
            ST_SQ: state_ff <= ST_PUSH;
            ST_PUSH: begin
               if (push_ok) begin
                  if (elast_ff) begin
                     // frame closed: nothing stays held
                     have_ff  <= 1'b0;
                     hg_ff    <= 1'b0;
                     ho_ff    <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else if (cur_last_ff) begin
                     state_ff <= ST_SQ;
                  end else begin
                     held_x_ff <= cur_x_ff;
                     held_y_ff <= cur_y_ff;
                     held_z_ff <= cur_z_ff;
                     hg_ff     <= cg_ff;
                     ho_ff     <= co_ff;
                     have_ff   <= 1'b1;
                     state_ff  <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_x_ff    <= req.point_x;
         cur_y_ff    <= req.point_y;
         cur_z_ff    <= req.point_z;
         cur_last_ff <= req.frame_end;
         dz_ff       <= dzs;
         dz_zero_ff  <= (dzs == '0);
         cg_ff       <= 1'b0;
         co_ff       <= 1'b0;
         // lone last point: own tests only
         e_x_ff   <= req.point_x;
         e_y_ff   <= req.point_y;
         e_z_ff   <= req.point_z;
         eg_ff    <= z_low(req.point_z, gz_ff);
         eo_ff    <= x_near(req.point_x, ox_ff);
         elast_ff <= 1'b1;
      end
      if (state_ff == ST_P2 && last_step) begin
         av_ff   <= a_mag + AVW'(lsgpf_pkg::ROUND_HALF);
         aneg_ff <= res_a[AW-1];
      end
      if (state_ff == ST_F1) begin
         prod_ff <= PW'(av_ff * lsgpf_pkg::RECIP_1E4);
      end
      if (state_ff == ST_F2) begin
         q_ff <= prod_ff[PW-1:lsgpf_pkg::RECIP_SHIFT];
      end
      if (state_ff == ST_F3) begin
         cg_ff    <= cg_new;
         co_ff    <= co_new;
         e_x_ff   <= held_x_ff;
         e_y_ff   <= held_y_ff;
         e_z_ff   <= held_z_ff;
         eg_ff    <= hg_ff || cg_new;
         eo_ff    <= ho_ff || co_new;
         elast_ff <= 1'b0;
      end
      if (state_ff == ST_SQ) begin
         sqx_ff <= (2*CB)'(ux * ux);
         sqy_ff <= (2*CB)'(uy * uy);
         rsq_ff <= 38'(rr_ff * rr_ff);
      end
      if (state_ff == ST_PUSH && push_ok && !elast_ff && cur_last_ff) begin
         // current point closes the frame after the held one
         e_x_ff   <= cur_x_ff;
         e_y_ff   <= cur_y_ff;
         e_z_ff   <= cur_z_ff;
         eg_ff    <= cg_ff || z_low(cur_z_ff, gz_ff);
         eo_ff    <= co_ff || x_near(cur_x_ff, ox_ff);
         elast_ff <= 1'b1;
      end
   end

   // ---------------- output stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_PUSH && push_ok) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PUSH && push_ok) begin
         rsp_x_ff <= e_x_ff;
         rsp_y_ff <= e_y_ff;
         rsp_z_ff <= e_z_ff;
         rsp_g_ff <= eg_ff;
         rsp_o_ff <= eo_ff;
         rsp_k_ff <= kept_w;
         rsp_r_ff <= kept_w && ((SQW'(sqx_ff) + SQW'(sqy_ff)) < SQW'(rsq_ff));
         rsp_l_ff <= elast_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_x       = rsp_x_ff;
   assign rsp.out_y       = rsp_y_ff;
   assign rsp.out_z       = rsp_z_ff;
   assign rsp.is_ground   = rsp_g_ff;
   assign rsp.near_origin = rsp_o_ff;
   assign rsp.kept        = rsp_k_ff;
   assign rsp.in_range    = rsp_r_ff;
   assign rsp.out_last    = rsp_l_ff;

`ifndef ASSERT_OFF
   a_pair_starts_cordic: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && have_ff) |=> (state_ff == ST_P1))
      else $error("pair transfer did not start the CORDIC pass");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P1 || state_ff == ST_P2) |-> (cnt_ff <= CNT_W'(CORDIC_STEPS - 1)))
      else $error("CORDIC step count overran the row");

   a_range_needs_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.in_range) |-> (rsp.kept && !rsp.is_ground && !rsp.near_origin))
      else $error("in-range flag on a point that is not kept");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && push_ok && elast_ff) |=> (!have_ff && state_ff == ST_IDLE))
      else $error("point still held after frame end");
`endif
endmodule

FILE: src/lsgpf_cordic_cell.sv
// One vectoring CORDIC iteration with a fixed shift, registered at its output.
module lsgpf_cordic_cell #(
   parameter int W     = lsgpf_pkg::COORD_BITS_DEF + lsgpf_pkg::CORDIC_GUARD,
   parameter int AW    = lsgpf_pkg::ANGLE_BITS,
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic signed [W-1:0]  src_x,
   input  logic signed [W-1:0]  src_y,
   input  logic signed [AW-1:0] src_a,
   output logic signed [W-1:0]  x_ff,
   output logic signed [W-1:0]  y_ff,
   output logic signed [AW-1:0] a_ff
);
   localparam logic signed [AW-1:0] ATAN = AW'(lsgpf_pkg::atan_udeg(5'(SHIFT)));

   logic signed [W-1:0]  xs, ys, x_in, y_in;
   logic signed [AW-1:0] a_in;

   always_comb begin
      xs = src_x >>> SHIFT;
      ys = src_y >>> SHIFT;
      // rotate towards the x axis
      if (!src_y[W-1]) begin
         x_in = src_x + ys;
         y_in = src_y - xs;
         a_in = src_a + ATAN;
      end else begin
         x_in = src_x - ys;
         y_in = src_y + xs;
         a_in = src_a - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      a_ff <= a_in;
   end
endmodule

FILE: src/lsgpf_cordic_chain.sv
// Row of CORDIC cells, each registered at its output; a vector entering cell 0 passes through all STEPS cells in turn.
module lsgpf_cordic_chain #(
   parameter int W     = lsgpf_pkg::COORD_BITS_DEF + lsgpf_pkg::CORDIC_GUARD,
   parameter int AW    = lsgpf_pkg::ANGLE_BITS,
   parameter int STEPS = lsgpf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic signed [W-1:0]  src_x,
   input  logic signed [W-1:0]  src_y,
   input  logic signed [AW-1:0] src_a,
   output logic signed [W-1:0]  res_x,
   output logic signed [W-1:0]  res_y,
   output logic signed [AW-1:0] res_a
);
   logic signed [W-1:0]  xw [STEPS+1];
   logic signed [W-1:0]  yw [STEPS+1];
   logic signed [AW-1:0] aw [STEPS+1];

   assign xw[0] = src_x;
   assign yw[0] = src_y;
   assign aw[0] = src_a;

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      lsgpf_cordic_cell #(.W(W), .AW(AW), .SHIFT(i)) u_cell (
         .clock (clock),
         .src_x (xw[i]),
         .src_y (yw[i]),
         .src_a (aw[i]),
         .x_ff  (xw[i+1]),
         .y_ff  (yw[i+1]),
         .a_ff  (aw[i+1])
      );
   end

   assign res_x = xw[STEPS];
   assign res_y = yw[STEPS];
   assign res_a = aw[STEPS];
endmodule

FILE: tb/tb.sv
// Self-checking testbench for the lidar slope ground point filter.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = lsgpf_pkg::COORD_BITS_DEF;
   localparam int STEPS = lsgpf_pkg::CORDIC_STEPS_DEF;
   localparam longint DZ_GAIN = 107922;
   localparam logic [2:0] REG_UNUSED = 3'd5;

   typedef struct {
      logic signed [CB-1:0] x, y, z;
      logic                 fe;
   } point_type;

   typedef struct {
      logic signed [CB-1:0] x, y, z;
      logic                 ground, origin, kept, in_range, last;
   } label_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsgpf_req_if #(.COORD_BITS(CB)) req_ch ();
   lsgpf_rsp_if #(.COORD_BITS(CB)) rsp_ch ();

   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [lsgpf_pkg::CFG_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lidar_slope_ground_point_filter DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register copies
   logic signed [14:0] cfg_mount  = lsgpf_pkg::MOUNT_RESET;
   logic [13:0]        cfg_tol    = lsgpf_pkg::TOL_RESET;
   logic signed [19:0] cfg_gz     = lsgpf_pkg::GZ_RESET;
   logic [18:0]        cfg_ox     = lsgpf_pkg::OX_RESET;
   logic [18:0]        cfg_radius = lsgpf_pkg::RADIUS_RESET;

   // held point of the predictor
   logic signed [CB-1:0] held_x = '0, held_y = '0, held_z = '0;
   logic held_ground = 1'b0, held_origin = 1'b0, have_held = 1'b0;

   point_type pending_points[$];
   label_type expected_labels[$];
   int     mismatches = 0;
   int     points_sent = 0;
   int     labels_seen = 0;
   bit     quiet_sender = 1'b0;
   bit     quiet_sink = 1'b0;

   longint atan_tab[16] = '{45000000, 26565051, 14036243, 7125016, 3576334, 1789911,
                            895174, 447614, 223811, 111906, 55953, 27976, 13988, 6994,
                            3497, 1749};

   function automatic longint iabs(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // pitch of a pair in hundredths of a degree
   function automatic longint pair_pitch(longint dx, longint dy, longint dz);
      longint cx, cy, ang, xs, ys;
      if (dz == 0) return 0;
      ang = 0;
      cx = iabs(dx) * 65536;
      cy = dy * 65536;
      for (int i = 0; i < STEPS; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy >= 0) begin
            cx += ys; cy -= xs;
         end else begin
            cx -= ys; cy += xs;
         end
      end
      cy = dz * DZ_GAIN;
      for (int i = 0; i < STEPS; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy >= 0) begin
            cx += ys; cy -= xs; ang += atan_tab[i];
         end else begin
            cx -= ys; cy += xs; ang -= atan_tab[i];
         end
      end
      if (ang >= 0) return (ang + 5000) / 10000;
      return -((-ang + 5000) / 10000);
   endfunction

   function automatic void push_label(logic signed [CB-1:0] x, y, z, bit g, o, l);
      label_type e;
      longint ux, uy, r;
      ux = iabs(longint'(x));
      uy = iabs(longint'(y));
      r = longint'(cfg_radius);
      e.x = x; e.y = y; e.z = z;
      e.ground = g; e.origin = o; e.kept = !g && !o;
      e.in_range = e.kept && (ux * ux + uy * uy < r * r);
      e.last = l;
      expected_labels.insert(expected_labels.size(), e);
   endfunction

   function automatic void label_point(point_type p);
      longint dev;
      bit cg, co;
      cg = 1'b0;
      co = 1'b0;
      if (have_held) begin
         dev = pair_pitch(longint'(p.x) - longint'(held_x), longint'(p.y) - longint'(held_y),
                          longint'(p.z) - longint'(held_z)) - longint'(cfg_mount);
         cg = (iabs(dev) <= longint'(cfg_tol)) || (held_z < cfg_gz);
         co = iabs(longint'(held_x)) < longint'(cfg_ox);
         push_label(held_x, held_y, held_z, held_ground || cg, held_origin || co, 1'b0);
      end
      if (p.fe) begin
         cg = cg || (p.z < cfg_gz);
         co = co || (iabs(longint'(p.x)) < longint'(cfg_ox));
         push_label(p.x, p.y, p.z, cg, co, 1'b1);
         have_held = 1'b0; held_ground = 1'b0; held_origin = 1'b0;
         held_x = '0; held_y = '0; held_z = '0;
      end else begin
         held_x = p.x; held_y = p.y; held_z = p.z;
         held_ground = cg; held_origin = co; have_held = 1'b1;
      end
   endfunction

   task automatic report(string what, longint got, longint want);
      mismatches++;
      $display("%0t: label %0d %s mismatch: got %0d expected %0d", $realtime, labels_seen,
               what, got, want);
   endtask

   // sender
   int     send_gap = 0;
   initial begin
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      req_ch.frame_end = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            label_point('{req_ch.point_x, req_ch.point_y, req_ch.point_z, req_ch.frame_end});
            points_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
               point_type p;
               p = pending_points.pop_front();
               req_ch.point_x <= p.x;
               req_ch.point_y <= p.y;
               req_ch.point_z <= p.z;
               req_ch.frame_end <= p.fe;
               req_ch.valid <= 1'b1;
               send_gap = quiet_sender ? 0 : $urandom_range(0, 10);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   int sink_stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_labels.size() == 0) begin
               report("unexpected transfer", 1, 0);
            end else begin
               label_type e;
               e = expected_labels.pop_front();
               if (rsp_ch.out_x !== e.x) report("out_x", rsp_ch.out_x, e.x);
               if (rsp_ch.out_y !== e.y) report("out_y", rsp_ch.out_y, e.y);
               if (rsp_ch.out_z !== e.z) report("out_z", rsp_ch.out_z, e.z);
               if (rsp_ch.is_ground !== e.ground) report("is_ground", rsp_ch.is_ground, e.ground);
               if (rsp_ch.near_origin !== e.origin)
                  report("near_origin", rsp_ch.near_origin, e.origin);
               if (rsp_ch.kept !== e.kept) report("kept", rsp_ch.kept, e.kept);
               if (rsp_ch.in_range !== e.in_range) report("in_range", rsp_ch.in_range, e.in_range);
               if (rsp_ch.out_last !== e.last) report("out_last", rsp_ch.out_last, e.last);
            end
            labels_seen++;
            sink_stall = quiet_sink ? 0 : $urandom_range(0, 10);
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= lsgpf_pkg::CFG_ADDR_BITS'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         lsgpf_pkg::REG_MOUNT_ANGLE:     cfg_mount = value[14:0];
         lsgpf_pkg::REG_ANGLE_TOLERANCE: cfg_tol = value[13:0];
         lsgpf_pkg::REG_GROUND_Z_LIMIT:  cfg_gz = value[19:0];
         lsgpf_pkg::REG_ORIGIN_X_LIMIT:  cfg_ox = value[18:0];
         lsgpf_pkg::REG_RANGE_RADIUS:    cfg_radius = value[18:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_points.size() != 0 || req_ch.valid || expected_labels.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic void add_point(int x, int y, int z, bit fe);
      point_type p;
      p.x = CB'(x);
      p.y = CB'(y);
      p.z = CB'(z);
      p.fe = fe;
      pending_points.insert(pending_points.size(), p);
   endfunction

   function automatic int full_coord();
      return int'($urandom_range(0, 32'hFFFFF)) - 524288;
   endfunction

   // mostly scan-like frames over a gently sloped surface, some wild points
   function automatic void add_random_points(int count);
      int x, y, z, flen, k;
      k = 0;
      while (k < count) begin
         flen = $urandom_range(1, 14);
         x = int'($urandom_range(0, 30000)) - 15000;
         y = int'($urandom_range(0, 30000)) - 15000;
         z = int'($urandom_range(0, 3000)) - 1500;
         for (int j = 0; j < flen && k < count; j++) begin
            case ($urandom_range(0, 9))
               0: add_point(full_coord(), full_coord(), full_coord(), 1'b0);
               1: add_point(int'($urandom_range(0, 40)) - 20, y, z, 1'b0);
               default: begin
                  x += int'($urandom_range(0, 800)) - 400;
                  y += int'($urandom_range(0, 800)) - 400;
                  z += int'($urandom_range(0, 300)) - 150;
                  add_point(x, y, z, 1'b0);
               end
            endcase
            k++;
         end
         pending_points[$].fe = 1'b1;
      end
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single-point frames, level, vertical, coincident, extremes
      add_point(0, 0, 0, 1'b1);
      add_point(9000, 100, 50, 1'b1);
      add_point(1000, 0, 0, 1'b0);
      add_point(2000, 0, 0, 1'b0);
      add_point(2000, 0, 500, 1'b0);
      add_point(2000, 0, 500, 1'b0);
      add_point(2000, 0, -800, 1'b0);
      add_point(524287, 524287, 524287, 1'b0);
      add_point(-524288, -524288, -524288, 1'b0);
      add_point(-524288, 0, 524287, 1'b0);
      add_point(5, 3, -1000, 1'b0);
      add_point(-9, 700, 0, 1'b0);
      add_point(3000, 4000, 10, 1'b1);
      add_point(-10, 0, -400, 1'b0);
      add_point(10, 0, -401, 1'b1);
      add_point(6000, 8000, 0, 1'b0);
      add_point(7000, 8000, 0, 1'b1);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         quiet_sender = (phase % 3) == 1;
         quiet_sink = (phase % 3) == 2;
         case (phase)
            1: begin
               csr_write(lsgpf_pkg::REG_MOUNT_ANGLE, -9000);
               csr_write(lsgpf_pkg::REG_ANGLE_TOLERANCE, 0);
               csr_write(lsgpf_pkg::REG_GROUND_Z_LIMIT, -524288);
               csr_write(lsgpf_pkg::REG_ORIGIN_X_LIMIT, 0);
               csr_write(lsgpf_pkg::REG_RANGE_RADIUS, 0);
            end
            2: begin
               csr_write(lsgpf_pkg::REG_MOUNT_ANGLE, 9000);
               csr_write(lsgpf_pkg::REG_ANGLE_TOLERANCE, 9000);
               csr_write(lsgpf_pkg::REG_GROUND_Z_LIMIT, 524287);
               csr_write(lsgpf_pkg::REG_ORIGIN_X_LIMIT, 524287);
               csr_write(lsgpf_pkg::REG_RANGE_RADIUS, 524287);
            end
            3: begin
               csr_write(lsgpf_pkg::REG_MOUNT_ANGLE, 32'hFFFF_FFFF);
               csr_write(lsgpf_pkg::REG_ANGLE_TOLERANCE, 32'hFFFF_FFFF);
               csr_write(lsgpf_pkg::REG_GROUND_Z_LIMIT, 32'hFFFF_FFFF);
               csr_write(lsgpf_pkg::REG_ORIGIN_X_LIMIT, 32'hFFFF_FFFF);
               csr_write(lsgpf_pkg::REG_RANGE_RADIUS, 32'hFFFF_FFFF);
               csr_write(REG_UNUSED, 32'h1234_5678);
            end
            4: begin
               csr_write(lsgpf_pkg::REG_MOUNT_ANGLE, 300);
               csr_write(lsgpf_pkg::REG_ANGLE_TOLERANCE, 800);
               csr_write(lsgpf_pkg::REG_GROUND_Z_LIMIT, -1000);
               csr_write(lsgpf_pkg::REG_ORIGIN_X_LIMIT, 15);
               csr_write(lsgpf_pkg::REG_RANGE_RADIUS, 12000);
            end
            5: begin
               csr_write(lsgpf_pkg::REG_MOUNT_ANGLE, $urandom_range(0, 1000) - 500);
               csr_write(lsgpf_pkg::REG_ANGLE_TOLERANCE, $urandom_range(0, 2000));
               csr_write(lsgpf_pkg::REG_GROUND_Z_LIMIT, $urandom_range(0, 1000) - 800);
               csr_write(lsgpf_pkg::REG_ORIGIN_X_LIMIT, $urandom_range(0, 30));
               csr_write(lsgpf_pkg::REG_RANGE_RADIUS, $urandom_range(5000, 20000));
            end
            default: ;
         endcase
         add_random_points(105);
         // hold off the sender until every label is back
         drain();
         add_random_points(105);
         drain();
      end

      $display("Sent %0d points over 6 register settings, checked %0d labels.",
               points_sent, labels_seen);
      if (mismatches == 0) begin
         $display("lidar_slope_ground_point_filter test passed");
      end else begin
         $display("lidar_slope_ground_point_filter test failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("lidar_slope_ground_point_filter test failed");
      $finish;
   end

endmodule
